### rtl/record_extent_translate_top_macros.svh
// Assertion macros for the record extent translate block.
// Used by ret_checker; needs nothing else.
`ifndef RECORD_EXTENT_TRANSLATE_TOP_MACROS_SVH
`define RECORD_EXTENT_TRANSLATE_TOP_MACROS_SVH

// overlapping implication, disabled in reset
`define RET_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ret assertion failed");

// next-cycle implication, disabled in reset
`define RET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ret assertion failed");

`endif

### rtl/ret_pkg.sv
// Shared types and constants for the record extent translate block.
// No dependencies.
package ret_pkg;

  localparam int MAX_EXTENTS_DEF = 64;

  localparam int BPC_W    = 22;
  localparam int RSIZE_W  = 17;
  localparam int LEN_W    = 32;
  localparam int START_W  = 48;
  localparam int RECNO_W  = 40;
  localparam int TARGET_W = 57;
  localparam int SPAN_W   = 54;
  localparam int ABS_W    = 49;
  localparam int OFF_W    = 21;
  localparam int NEED_W   = 8;
  localparam int NUM_W    = 24;
  localparam int CFG_IDX_W = 1;

  // divider: 32 quotient bits, 4 per cycle
  localparam int DIV_Q_W     = 32;
  localparam int DIV_PER_CYC = 4;
  localparam int DIV_CYCLES  = DIV_Q_W / DIV_PER_CYC;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam logic [1:0] MODE_CLEAR     = 2'd0;
  localparam logic [1:0] MODE_APPEND    = 2'd1;
  localparam logic [1:0] MODE_TRANSLATE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SPARSE = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BPC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RSIZE = 1'b1;

  localparam logic [BPC_W-1:0]   BPC_RESET   = 22'd4096;
  localparam logic [RSIZE_W-1:0] RSIZE_RESET = 17'd1024;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WALK,
    S_DIV_POS,
    S_DIV_NEED,
    S_DONE
  } state_t;

endpackage

### rtl/ret_if.sv
// Item channel interfaces for the record extent translate block.
// Depends on ret_pkg for field widths.
interface ret_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [ret_pkg::LEN_W-1:0]      extent_clusters;
  logic [ret_pkg::START_W-1:0]    extent_start;
  logic [ret_pkg::RECNO_W-1:0]    record_number;

  modport source (output valid, mode, extent_clusters, extent_start, record_number,
                  input ready);
  modport sink (input valid, mode, extent_clusters, extent_start, record_number,
                output ready);
endinterface

interface ret_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ret_pkg::ABS_W-1:0]     absolute_cluster;
  logic [ret_pkg::OFF_W-1:0]     offset_in_cluster;
  logic [ret_pkg::NEED_W-1:0]    clusters_needed;

  modport source (output valid, status, absolute_cluster, offset_in_cluster,
                  clusters_needed, input ready);
  modport sink (input valid, status, absolute_cluster, offset_in_cluster,
                clusters_needed, output ready);
endinterface

### rtl/record_extent_translate_top.sv
// Record extent translate: extent table in one synchronous memory, walked one entry
// per cycle. Depends on ret_pkg and the channel interfaces in ret_if.sv.
//
// One item is in work at a time. Clear and append go straight from accepting the item
// to the hand-off. A translate that lands in a data extent first accepts the item, then
// does the record offset multiply, then walks the extents one per cycle through the
// single read port of the table, each entry passing the read register and the span
// multiply register, then runs the two divisions by the cluster size (4 quotient bits
// a cycle), and last hands the result to the output register. A sparse hit skips the
// divisions; an offset beyond the table is reported once every extent has been walked.
// The hand-off waits while the output register still holds an unread result.
// A finished result waits in that register while the next item is accepted.
module record_extent_translate_top #(
  parameter int MAX_EXTENTS = ret_pkg::MAX_EXTENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ret_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ret_pkg::BPC_W-1:0]       wr_data,
  ret_cmd_if.sink                         cmd,
  ret_rsp_if.source                       rsp
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = ret_pkg::LEN_W + ret_pkg::START_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

  ret_pkg::state_t state, state_next;

  logic [ret_pkg::BPC_W-1:0]    bpc;
  logic [ret_pkg::RSIZE_W-1:0]  rsize;
  logic [CW-1:0]                count;

  logic [EW-1:0]                mem [MAX_EXTENTS];
  logic [EW-1:0]                rd_q;
  logic [AW-1:0]                rd_addr;

  logic [ret_pkg::RECNO_W-1:0]  recno;
  logic [ret_pkg::TARGET_W-1:0] target;
  logic [ret_pkg::TARGET_W-1:0] base;
  logic [CW-1:0]                iss;
  logic                         rd_v;
  logic                         sp_v;
  logic [ret_pkg::SPAN_W-1:0]   span;
  logic [ret_pkg::START_W-1:0]  sp_start;
  logic [ret_pkg::START_W-1:0]  hit_start;

  logic [ret_pkg::BPC_W-1:0]    rem;
  logic [ret_pkg::DIV_Q_W-1:0]  dq;
  logic [ret_pkg::DIV_CNT_W-1:0] dcnt;

  logic [1:0]                   res_status;
  logic [ret_pkg::ABS_W-1:0]    res_abs;
  logic [ret_pkg::OFF_W-1:0]    res_off;
  logic [ret_pkg::NEED_W-1:0]   res_need;

  logic [1:0]                   out_status;
  logic [ret_pkg::ABS_W-1:0]    out_abs;
  logic [ret_pkg::OFF_W-1:0]    out_off;
  logic [ret_pkg::NEED_W-1:0]   out_need;
  logic                         out_valid;

  logic                         accept;
  logic                         out_free;
  logic                         hit;
  logic                         issue;
  logic                         walk_end;
  logic                         div_last;
  logic [ret_pkg::TARGET_W:0]   span_end;
  logic [ret_pkg::TARGET_W-1:0] rel_off;
  logic [ret_pkg::BPC_W-1:0]    rem_step;
  logic [ret_pkg::DIV_Q_W-1:0]  dq_step;
  logic [ret_pkg::NUM_W-1:0]    need_num;
  logic [ret_pkg::NEED_W-1:0]   need_sat;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;
  assign cmd.ready = (state == ret_pkg::S_IDLE);

  assign span_end = {1'b0, base} + {4'b0, span};
  assign hit      = (state == ret_pkg::S_WALK) && sp_v && ({1'b0, target} < span_end);
  assign issue    = (state == ret_pkg::S_WALK) && (iss < count) && !hit;
  assign walk_end = (state == ret_pkg::S_WALK) && (iss >= count) && !rd_v && !sp_v;
  assign rd_addr  = iss[AW-1:0];
  assign rel_off  = target - base;
  assign div_last = (dcnt == ret_pkg::DIV_CNT_W'(ret_pkg::DIV_CYCLES - 1));

  // restoring division, DIV_PER_CYC quotient bits per cycle
  always_comb begin
    logic [ret_pkg::BPC_W:0] t;
    rem_step = rem;
    dq_step  = dq;
    for (int k = 0; k < ret_pkg::DIV_PER_CYC; k++) begin
      t = {rem_step, dq_step[ret_pkg::DIV_Q_W-1]};
      if (t >= {1'b0, bpc}) begin
        t = t - {1'b0, bpc};
        dq_step = {dq_step[ret_pkg::DIV_Q_W-2:0], 1'b1};
      end else begin
        dq_step = {dq_step[ret_pkg::DIV_Q_W-2:0], 1'b0};
      end
      rem_step = t[ret_pkg::BPC_W-1:0];
    end
  end

  assign need_num = {2'b0, rem_step} + {7'b0, rsize} + {2'b0, bpc} - 24'd1;
  assign need_sat = (dq_step[ret_pkg::DIV_Q_W-1:ret_pkg::NEED_W] != '0) ? 8'hFF :
                    dq_step[ret_pkg::NEED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ret_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ret_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (cmd.mode == ret_pkg::MODE_TRANSLATE) ? ret_pkg::S_MUL :
                                                               ret_pkg::S_DONE;
        end
      end
      ret_pkg::S_MUL: state_next = ret_pkg::S_WALK;
      ret_pkg::S_WALK: begin
        if (hit) begin
          state_next = (sp_start == '0) ? ret_pkg::S_DONE : ret_pkg::S_DIV_POS;
        end else if (walk_end) begin
          state_next = ret_pkg::S_DONE;
        end
      end
      ret_pkg::S_DIV_POS: if (div_last) state_next = ret_pkg::S_DIV_NEED;
      ret_pkg::S_DIV_NEED: if (div_last) state_next = ret_pkg::S_DONE;
      ret_pkg::S_DONE: if (out_free) state_next = ret_pkg::S_IDLE;
      default: state_next = ret_pkg::S_IDLE;
    endcase
  end

  // extent table
  always_ff @(posedge clk) begin
    if (accept && cmd.mode == ret_pkg::MODE_APPEND && count < MAX_CNT) begin
      mem[count[AW-1:0]] <= {cmd.extent_clusters, cmd.extent_start};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpc       <= ret_pkg::BPC_RESET;
      rsize     <= ret_pkg::RSIZE_RESET;
      count     <= '0;
      rd_v      <= 1'b0;
      sp_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          ret_pkg::CFG_BPC:   bpc   <= wr_data;
          ret_pkg::CFG_RSIZE: rsize <= wr_data[ret_pkg::RSIZE_W-1:0];
          default: ;
        endcase
      end

      rd_v <= issue;
      sp_v <= rd_v && !hit;

      if (accept) begin
        case (cmd.mode)
          ret_pkg::MODE_CLEAR: count <= '0;
          ret_pkg::MODE_APPEND: if (count < MAX_CNT) count <= count + 1'b1;
          default: ;
        endcase
      end

      if (state == ret_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    span     <= {22'b0, rd_q[EW-1:ret_pkg::START_W]} * {32'b0, bpc};
    sp_start <= rd_q[ret_pkg::START_W-1:0];
    if (issue) iss <= iss + 1'b1;

    case (state)
      ret_pkg::S_IDLE: begin
        recno    <= cmd.record_number;
        res_abs  <= '0;
        res_off  <= '0;
        res_need <= '0;
        if (cmd.mode == ret_pkg::MODE_APPEND && count >= MAX_CNT) begin
          res_status <= ret_pkg::ST_FULL;
        end else begin
          res_status <= ret_pkg::ST_OK;
        end
      end
      ret_pkg::S_MUL: begin
        target <= {17'b0, recno} * {40'b0, rsize};
        base   <= '0;
        iss    <= '0;
      end
      ret_pkg::S_WALK: begin
        if (hit) begin
          hit_start <= sp_start;
          rem  <= rel_off[ret_pkg::SPAN_W-1:ret_pkg::DIV_Q_W];
          dq   <= rel_off[ret_pkg::DIV_Q_W-1:0];
          dcnt <= '0;
          if (sp_start == '0) res_status <= ret_pkg::ST_SPARSE;
        end else if (sp_v) begin
          base <= span_end[ret_pkg::TARGET_W-1:0];
        end
        if (walk_end) res_status <= ret_pkg::ST_BEYOND;
      end
      ret_pkg::S_DIV_POS: begin
        dcnt <= dcnt + 1'b1;
        if (div_last) begin
          res_abs <= {1'b0, hit_start} + {17'b0, dq_step};
          res_off <= rem_step[ret_pkg::OFF_W-1:0];
          rem     <= '0;
          dq      <= {8'b0, need_num};
        end else begin
          rem <= rem_step;
          dq  <= dq_step;
        end
      end
      ret_pkg::S_DIV_NEED: begin
        dcnt <= dcnt + 1'b1;
        rem  <= rem_step;
        dq   <= dq_step;
        if (div_last) begin
          res_need   <= need_sat;
          res_status <= ret_pkg::ST_OK;
        end
      end
      default: ;
    endcase

    if (state == ret_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_abs    <= res_abs;
      out_off    <= res_off;
      out_need   <= res_need;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.absolute_cluster  = out_abs;
  assign rsp.offset_in_cluster = out_off;
  assign rsp.clusters_needed   = out_need;

endmodule

### rtl/ret_checker.sv
// Port-level checks for record_extent_translate_top, attached by bind.
// Depends on ret_pkg and record_extent_translate_top_macros.svh.
`include "record_extent_translate_top_macros.svh"

module ret_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [1:0]                   rsp_status,
  input logic [ret_pkg::ABS_W-1:0]    rsp_abs,
  input logic [ret_pkg::OFF_W-1:0]    rsp_off,
  input logic [ret_pkg::NEED_W-1:0]   rsp_need
);

  logic [1+ret_pkg::ABS_W+ret_pkg::OFF_W+ret_pkg::NEED_W:0] rsp_word;

  assign rsp_word = {rsp_status, rsp_abs, rsp_off, rsp_need};

  `RET_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `RET_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_word))
  `RET_ASSERT_NOW(a_fail_zero, clk, rst, rsp_valid && rsp_status != ret_pkg::ST_OK, rsp_abs == '0 && rsp_off == '0 && rsp_need == '0)
  `RET_ASSERT_NEXT(a_one_item, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind record_extent_translate_top ret_checker u_ret_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_abs    (rsp.absolute_cluster),
  .rsp_off    (rsp.offset_in_cluster),
  .rsp_need   (rsp.clusters_needed)
);

### tb/tb_record_extent_translate_top.sv
// Self-checking testbench for record_extent_translate_top: table-driven directed items,
// then random extent tables and lookups checked against a local predictor.
// Depends on ret_pkg, ret_if.sv (ret_cmd_if, ret_rsp_if) and the top module.
`timescale 1ns / 1ps

module tb_record_extent_translate_top;

  localparam int         MAX_EXT  = ret_pkg::MAX_EXTENTS_DEF;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int         PHASES   = 8;
  localparam int         PHASE_OPS = 125;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [ret_pkg::LEN_W-1:0]   clusters;
    logic [ret_pkg::START_W-1:0] start;
    logic [ret_pkg::RECNO_W-1:0] recno;
  } op_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [ret_pkg::ABS_W-1:0]  cluster;
    logic [ret_pkg::OFF_W-1:0]  offset;
    logic [ret_pkg::NEED_W-1:0] need;
  } reply_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    op_t                           op;
    reply_t                        want;
    logic [ret_pkg::CFG_IDX_W-1:0] idx;
    logic [ret_pkg::BPC_W-1:0]     val;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [ret_pkg::CFG_IDX_W-1:0] wr_index;
  logic [ret_pkg::BPC_W-1:0]     wr_data;

  ret_cmd_if cmd_ch ();
  ret_rsp_if rsp_ch ();

  record_extent_translate_top DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd_ch),
    .rsp      (rsp_ch)
  );

  always #10 clk = ~clk;

  // local copy of the extent table and registers
  logic [ret_pkg::LEN_W-1:0]   len_tab [MAX_EXT];
  logic [ret_pkg::START_W-1:0] start_tab [MAX_EXT];
  int                          ext_cnt = 0;
  logic [ret_pkg::BPC_W-1:0]   cfg_bpc = ret_pkg::BPC_RESET;
  logic [ret_pkg::RSIZE_W-1:0] cfg_rsize = ret_pkg::RSIZE_RESET;

  reply_t pending_replies [$];
  row_t   plan [$];
  int     mismatches = 0;
  bit     steady = 0;
  bit     cmd_live = 0;
  bit     wr_live = 0;

  function automatic reply_t predict_extent_reply(op_t op);
    reply_t r;
    logic [63:0] target, base, span, rel_off, cl, off, need;
    bit hit;
    r = '0;
    hit = 0;
    base = '0;
    case (op.mode)
      ret_pkg::MODE_CLEAR: ext_cnt = 0;
      ret_pkg::MODE_APPEND: begin
        if (ext_cnt >= MAX_EXT) begin
          r.status = ret_pkg::ST_FULL;
        end else begin
          len_tab[ext_cnt] = op.clusters;
          start_tab[ext_cnt] = op.start;
          ext_cnt++;
        end
      end
      ret_pkg::MODE_TRANSLATE: begin
        target = 64'(op.recno) * 64'(cfg_rsize);
        r.status = ret_pkg::ST_BEYOND;
        for (int i = 0; i < ext_cnt && !hit; i++) begin
          span = 64'(len_tab[i]) * 64'(cfg_bpc);
          if (target < base + span) begin
            hit = 1;
            rel_off = target - base;
            if (start_tab[i] == '0) begin
              r.status = ret_pkg::ST_SPARSE;
            end else begin
              cl = rel_off / cfg_bpc;
              off = rel_off % cfg_bpc;
              need = (off + cfg_rsize + cfg_bpc - 1) / cfg_bpc;
              r.status = ret_pkg::ST_OK;
              r.cluster = ret_pkg::ABS_W'(64'(start_tab[i]) + cl);
              r.offset = off[ret_pkg::OFF_W-1:0];
              r.need = (need > 255) ? 8'hFF : need[ret_pkg::NEED_W-1:0];
            end
          end else begin
            base += span;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // record number that mostly lands inside the loaded table
  function automatic logic [ret_pkg::RECNO_W-1:0] pick_record();
    logic [63:0] total, target;
    int r;
    r = $urandom_range(99);
    total = '0;
    for (int i = 0; i < ext_cnt; i++) total += 64'(len_tab[i]) * 64'(cfg_bpc);
    if (r < 12) return {8'($urandom_range(255)), $urandom};
    if (r < 22 || total == 0 || cfg_rsize == 0) begin
      return ret_pkg::RECNO_W'($urandom_range(300));
    end
    target = {$urandom, $urandom} % (total + total / 8 + 1);
    target = target / cfg_rsize;
    if ((target >> ret_pkg::RECNO_W) != 0) return {8'($urandom_range(255)), $urandom};
    return target[ret_pkg::RECNO_W-1:0];
  endfunction

  function automatic op_t make_append();
    op_t op;
    int r;
    op = '0;
    op.mode = ret_pkg::MODE_APPEND;
    r = $urandom_range(99);
    if (r < 10) op.clusters = '0;
    else if (r < 20) op.clusters = $urandom;
    else if (r < 25) op.clusters = '1;
    else op.clusters = $urandom_range(64, 1);
    r = $urandom_range(99);
    if (r < 10) op.start = '0;
    else if (r < 15) op.start = '1;
    else op.start = {16'($urandom_range(65535)), $urandom};
    return op;
  endfunction

  function automatic row_t op_row(logic [1:0] m, logic [ret_pkg::LEN_W-1:0] n,
                                  logic [ret_pkg::START_W-1:0] s,
                                  logic [ret_pkg::RECNO_W-1:0] rn);
    row_t t;
    t.kind = ROW_ITEM;
    t.op = {m, n, s, rn};
    t.want = '0;
    t.idx = '0;
    t.val = '0;
    return t;
  endfunction

  function automatic row_t known(row_t t, logic [1:0] st, logic [ret_pkg::ABS_W-1:0] cl,
                                 logic [ret_pkg::OFF_W-1:0] off,
                                 logic [ret_pkg::NEED_W-1:0] nd);
    t.kind = ROW_KNOWN;
    t.want = {st, cl, off, nd};
    return t;
  endfunction

  function automatic row_t reg_row(logic [ret_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ret_pkg::BPC_W-1:0] val);
    row_t t;
    t = op_row(MODE_NOP, 0, 0, 0);
    t.kind = ROW_REG;
    t.idx = idx;
    t.val = val;
    return t;
  endfunction

  task automatic lower_cmd();
    if (cmd_live) begin
      cmd_ch.valid <= 1'b0;
      cmd_live = 0;
    end
  endtask

  task automatic drain();
    lower_cmd();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [ret_pkg::CFG_IDX_W-1:0] idx,
                           logic [ret_pkg::BPC_W-1:0] val);
    lower_cmd();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    wr_live = 1;
    if (idx == ret_pkg::CFG_BPC) cfg_bpc = val;
    else cfg_rsize = val[ret_pkg::RSIZE_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_op(op_t op, bit use_want, reply_t want);
    reply_t pred;
    if (wr_live) begin
      wr_en <= 1'b0;
      wr_live = 0;
    end
    while (!steady && $urandom_range(99) < 31) begin
      lower_cmd();
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= op.mode;
    cmd_ch.extent_clusters <= op.clusters;
    cmd_ch.extent_start <= op.start;
    cmd_ch.record_number <= op.recno;
    cmd_live = 1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pred = predict_extent_reply(op);
    pending_replies.push_back(use_want ? want : pred);
  endtask

  always @(posedge clk) begin
    reply_t want, got;
    rsp_ch.ready <= steady || ($urandom_range(99) >= 31);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.absolute_cluster, rsp_ch.offset_in_cluster,
             rsp_ch.clusters_needed};
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none pending: got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.cluster !== want.cluster) begin
          $display("%0t: absolute_cluster exp %h got %h", $time, want.cluster, got.cluster);
          mismatches++;
        end
        if (got.offset !== want.offset) begin
          $display("%0t: offset_in_cluster exp %h got %h", $time, want.offset, got.offset);
          mismatches++;
        end
        if (got.need !== want.need) begin
          $display("%0t: clusters_needed exp %0d got %0d", $time, want.need, got.need);
          mismatches++;
        end
      end
    end
  end

  initial begin
    op_t op;
    int quota, n, r;
    logic [ret_pkg::BPC_W-1:0] bpc;
    logic [ret_pkg::RSIZE_W-1:0] rs;

    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= '0;
    cmd_ch.extent_clusters <= '0;
    cmd_ch.extent_start <= '0;
    cmd_ch.record_number <= '0;

    // reset registers: 4096-byte clusters, 1024-byte records
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0), ret_pkg::ST_BEYOND,
                         0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_APPEND, 0, 100, 0), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_APPEND, 4, 1000, 0), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_APPEND, 2, 0, 0), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_APPEND, '1, '1, 0), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0), ret_pkg::ST_OK,
                         1000, 0, 1));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 17), ret_pkg::ST_SPARSE,
                         0, 0, 0));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 5));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, '1, '1, '1), ret_pkg::ST_BEYOND,
                         0, 0, 0));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 40'd1 << 20));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 24));
    plan.push_back(known(op_row(MODE_NOP, '1, '1, '1), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_CLEAR, '1, '1, '1), ret_pkg::ST_OK, 0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0), ret_pkg::ST_BEYOND,
                         0, 0, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_APPEND, 8, 50, 0), ret_pkg::ST_OK, 0, 0, 0));
    // zero cluster size: nothing is covered
    plan.push_back(reg_row(ret_pkg::CFG_BPC, 0));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0), ret_pkg::ST_BEYOND,
                         0, 0, 0));
    // out-of-range registers: count saturates, then offset wider than 21 bits
    plan.push_back(reg_row(ret_pkg::CFG_BPC, 1));
    plan.push_back(reg_row(ret_pkg::CFG_RSIZE, 22'h1FFFF));
    plan.push_back(known(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0), ret_pkg::ST_OK,
                         50, 0, 255));
    plan.push_back(reg_row(ret_pkg::CFG_BPC, 22'h3FFFFF));
    plan.push_back(reg_row(ret_pkg::CFG_RSIZE, 1));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 3000000));
    plan.push_back(reg_row(ret_pkg::CFG_BPC, 512));
    plan.push_back(reg_row(ret_pkg::CFG_RSIZE, 65536));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 0));
    plan.push_back(op_row(ret_pkg::MODE_APPEND, 32'h8000_0000, 1, 0));
    plan.push_back(op_row(ret_pkg::MODE_TRANSLATE, 0, 0, 100000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_op(plan[i].op, plan[i].kind == ROW_KNOWN, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin bpc = 512; rs = 256; end
        1: begin bpc = 2097152; rs = 65536; end
        2: begin bpc = 4096; rs = 1024; end
        4: begin bpc = 512; rs = 65536; end
        5: begin bpc = 2097152; rs = 256; end
        6: begin
          bpc = ret_pkg::BPC_W'($urandom);
          rs = ret_pkg::RSIZE_W'($urandom);
        end
        default: begin
          bpc = ret_pkg::BPC_W'($urandom_range(2097152, 512));
          rs = ret_pkg::RSIZE_W'($urandom_range(65536, 256));
        end
      endcase
      drain();
      write_reg(ret_pkg::CFG_BPC, bpc);
      write_reg(ret_pkg::CFG_RSIZE, ret_pkg::BPC_W'(rs));
      steady = (phase == 2);
      quota = 0;
      while (quota < PHASE_OPS) begin
        if ($urandom_range(99) < 75) begin
          if ($urandom_range(99) < 70) begin
            op = '0;
            op.mode = ret_pkg::MODE_CLEAR;
            send_op(op, 0, '0);
            quota++;
          end
          r = $urandom_range(99);
          if (r < 80) n = $urandom_range(12, 1);
          else if (r < 95) n = $urandom_range(63, 13);
          else n = $urandom_range(70, 60);
          repeat (n) begin
            send_op(make_append(), 0, '0);
            quota++;
          end
          repeat ($urandom_range(12, 1)) begin
            op = {ret_pkg::MODE_TRANSLATE, $urandom,
                  {16'($urandom_range(65535)), $urandom}, pick_record()};
            send_op(op, 0, '0);
            quota++;
          end
        end else begin
          op = {2'($urandom_range(3)), $urandom, {16'($urandom_range(65535)), $urandom},
                {8'($urandom_range(255)), $urandom}};
          send_op(op, 0, '0);
          quota++;
        end
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_record_extent_translate_top: clean");
    end else begin
      $display("tb_record_extent_translate_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_record_extent_translate_top: errors");
    $finish;
  end

endmodule
